// ===== rtl/uerl_pkg.sv =====
// Package: shared types and constants for the ultrasonic echo ranger with LED blinker.
`default_nettype none

package uerl_pkg;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_READ = 2'd1,
        FUNC_TRIG = 2'd2,
        FUNC_NOP  = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_LED_BLINK     = 1'b0,
        CFG_TRIGGER_WIDTH = 1'b1
    } cfg_index_t;

    // Distance bands of the LED blinker
    typedef enum logic [2:0] {
        BAND_NONE = 3'd0,
        BAND_1    = 3'd1,
        BAND_2    = 3'd2,
        BAND_3    = 3'd3,
        BAND_4    = 3'd4,
        BAND_5    = 3'd5,
        BAND_6    = 3'd6
    } band_t;

    // Per-item strobes, already qualified by the pipeline advancing
    typedef struct packed {
        logic tick;
        logic read;
        logic trig;
    } item_ctl_t;

    localparam int READ_BITS    = 24;
    localparam int TRIG_BITS    = 10;
    localparam int COUNT_BITS   = 4;

    localparam logic [READ_BITS-1:0]  READ_MAX            = '1;
    localparam logic [TRIG_BITS-1:0]  TRIGGER_WIDTH_RESET = 10'd20;
    localparam logic [COUNT_BITS-1:0] BLINK_COUNT_RESET   = 4'd1;

    // Band limits in microseconds (58 us per cm of range)
    localparam int BAND1_LIMIT = 10 * 58;
    localparam int BAND2_LIMIT = 25 * 58;
    localparam int BAND3_LIMIT = 50 * 58;
    localparam int BAND4_LIMIT = 75 * 58;
    localparam int BAND5_LIMIT = 100 * 58;

    // Toggle periods in measurements
    localparam logic [COUNT_BITS-1:0] PERIOD_2 = 4'd2;
    localparam logic [COUNT_BITS-1:0] PERIOD_3 = 4'd3;
    localparam logic [COUNT_BITS-1:0] PERIOD_4 = 4'd4;
    localparam logic [COUNT_BITS-1:0] PERIOD_5 = 4'd5;
    localparam logic [COUNT_BITS-1:0] PERIOD_6 = 4'd10;

endpackage

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger_led_core.sv =====
// Top level: ultrasonic echo ranger with LED distance blinker.
//
// Input channel (s_*): one transaction per item. func TICK is one microsecond
// sample of the echo pin, READ returns the latest echo width once, TRIG starts
// a trigger pulse of trigger_width ticks, the fourth code changes nothing.
// Result channel (m_*): exactly one transaction per input item, in order:
// read data and freshness flag, trigger pin level during the item and LED
// level after it.
// Configuration channel (cfg_*): index 0 switches the LED blinker on or off,
// index 1 trigger_width; always ready. The user must write these registers
// only while no item is in flight; the block does not enforce this.
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single state-update stage between the input and result registers.
// When the receiver stalls, the result holds and the input register still
// takes one more item; s_ready drops only when both registers are full.
// Synchronous active-low reset empties both registers, clears the echo,
// blinker and trigger state and restores the register defaults.
`default_nettype none

module ultrasonic_echo_ranger_led_core #(
    parameter int TIME_BITS = 24
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input items
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_func,
    input  wire logic                                s_echo_level,
    // Results
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [uerl_pkg::READ_BITS-1:0]           m_read_data,
    output logic                                     m_data_fresh,
    output logic                                     m_trigger_level,
    output logic                                     m_led_level,
    // Configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [uerl_pkg::TRIG_BITS-1:0]      cfg_data
);

    logic                             blink_on_reg;
    logic [uerl_pkg::TRIG_BITS-1:0]   trigger_width_reg;

    logic                             in_valid_reg;
    uerl_pkg::func_t                  in_func_reg;
    logic                             in_echo_reg;

    logic                             out_valid_reg;
    logic [uerl_pkg::READ_BITS-1:0]   out_read_data_reg;
    logic                             out_fresh_reg;
    logic                             out_trig_reg;
    logic                             out_led_reg;

    logic                             advance;
    uerl_pkg::item_ctl_t              ctl;
    logic                             meas_strobe;
    logic [TIME_BITS-1:0]             meas_width;
    logic [uerl_pkg::READ_BITS-1:0]   read_data;
    logic                             data_fresh;
    logic                             trigger_level;
    logic                             led_next;

    // Handshake: the item moves on when the result register is free or drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Function decode, qualified by advance
    always_comb begin
        ctl = '0;
        case (in_func_reg)
            uerl_pkg::FUNC_TICK: ctl.tick = advance;
            uerl_pkg::FUNC_READ: ctl.read = advance;
            uerl_pkg::FUNC_TRIG: ctl.trig = advance;
            default:             ctl      = '0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_on_reg      <= 1'b0;
            trigger_width_reg <= uerl_pkg::TRIGGER_WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (uerl_pkg::cfg_index_t'(cfg_index))
                uerl_pkg::CFG_LED_BLINK:     blink_on_reg      <= cfg_data[0];
                uerl_pkg::CFG_TRIGGER_WIDTH: trigger_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= uerl_pkg::func_t'(s_func);
            in_echo_reg <= s_echo_level;
        end
    end

    uerl_echo #(
        .TIME_BITS (TIME_BITS)
    ) u_echo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .echo_level  (in_echo_reg),
        .meas_strobe (meas_strobe),
        .meas_width  (meas_width),
        .read_data   (read_data),
        .data_fresh  (data_fresh)
    );

    uerl_blink #(
        .TIME_BITS (TIME_BITS)
    ) u_blink (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .blink_on     (blink_on_reg),
        .meas_strobe  (meas_strobe),
        .meas_width   (meas_width),
        .led_next_out (led_next)
    );

    uerl_trigger u_trigger (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .trigger_width (trigger_width_reg),
        .trigger_level (trigger_level)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_read_data_reg <= read_data;
            out_fresh_reg     <= data_fresh;
            out_trig_reg      <= trigger_level;
            out_led_reg       <= led_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_read_data     = out_read_data_reg;
    assign m_data_fresh    = out_fresh_reg;
    assign m_trigger_level = out_trig_reg;
    assign m_led_level     = out_led_reg;

endmodule

`default_nettype wire

// ===== rtl/uerl_echo.sv =====
// Echo pulse width counter, measurement latch and read-out.
`default_nettype none

module uerl_echo #(
    parameter int TIME_BITS = 24
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire uerl_pkg::item_ctl_t             ctl,
    input  wire logic                            echo_level,
    output logic                                 meas_strobe,
    output logic [TIME_BITS-1:0]                 meas_width,
    output logic [uerl_pkg::READ_BITS-1:0]       read_data,
    output logic                                 data_fresh
);

    localparam int EXT_W = TIME_BITS + uerl_pkg::READ_BITS;
    localparam logic [TIME_BITS-1:0] COUNT_MAX = '1;

    logic                 echo_prev_reg, echo_prev_next;
    logic [TIME_BITS-1:0] count_reg, count_next;
    logic [TIME_BITS-1:0] measured_reg, measured_next;
    logic                 valid_reg, valid_next;
    logic [EXT_W-1:0]     meas_ext;
    logic                 read_sat;

    // Saturate the latched width to the read field
    assign meas_ext = EXT_W'(measured_reg);
    assign read_sat = meas_ext > EXT_W'(uerl_pkg::READ_MAX);

    // Edge detect, width count, latch on falling edge, read clears valid
    always_comb begin
        echo_prev_next = echo_prev_reg;
        count_next     = count_reg;
        measured_next  = measured_reg;
        valid_next     = valid_reg;
        meas_strobe    = 1'b0;
        read_data      = '0;
        data_fresh     = 1'b0;
        if (ctl.tick) begin
            if (echo_level && !echo_prev_reg) begin
                count_next = TIME_BITS'(1);
            end else if (echo_level) begin
                if (count_reg != COUNT_MAX) begin
                    count_next = count_reg + TIME_BITS'(1);
                end
            end else if (echo_prev_reg) begin
                measured_next = count_reg;
                valid_next    = 1'b1;
                meas_strobe   = 1'b1;
            end
            echo_prev_next = echo_level;
        end else if (ctl.read && valid_reg) begin
            read_data  = read_sat ? uerl_pkg::READ_MAX
                                  : meas_ext[uerl_pkg::READ_BITS-1:0];
            data_fresh = 1'b1;
            valid_next = 1'b0;
        end
    end

    // Width handed to the blinker is the count being latched
    assign meas_width = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_prev_reg <= 1'b0;
            count_reg     <= '0;
            measured_reg  <= '0;
            valid_reg     <= 1'b0;
        end else begin
            echo_prev_reg <= echo_prev_next;
            count_reg     <= count_next;
            measured_reg  <= measured_next;
            valid_reg     <= valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uerl_blink.sv =====
// LED blinker: classifies each new width into a band; LED on in band 1, else toggled per band period.
`default_nettype none

module uerl_blink #(
    parameter int TIME_BITS = 24
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 blink_on,
    input  wire logic                 meas_strobe,
    input  wire logic [TIME_BITS-1:0] meas_width,
    output logic                      led_next_out
);

    uerl_pkg::band_t                      band_reg, band_next, band_sel;
    logic [uerl_pkg::COUNT_BITS-1:0]      count_reg, count_next, period_sel;
    logic                                 led_reg, led_next;

    // Band decode of the new width
    always_comb begin
        if (meas_width < TIME_BITS'(uerl_pkg::BAND1_LIMIT)) begin
            band_sel   = uerl_pkg::BAND_1;
            period_sel = uerl_pkg::PERIOD_2;
        end else if (meas_width < TIME_BITS'(uerl_pkg::BAND2_LIMIT)) begin
            band_sel   = uerl_pkg::BAND_2;
            period_sel = uerl_pkg::PERIOD_2;
        end else if (meas_width < TIME_BITS'(uerl_pkg::BAND3_LIMIT)) begin
            band_sel   = uerl_pkg::BAND_3;
            period_sel = uerl_pkg::PERIOD_3;
        end else if (meas_width < TIME_BITS'(uerl_pkg::BAND4_LIMIT)) begin
            band_sel   = uerl_pkg::BAND_4;
            period_sel = uerl_pkg::PERIOD_4;
        end else if (meas_width < TIME_BITS'(uerl_pkg::BAND5_LIMIT)) begin
            band_sel   = uerl_pkg::BAND_5;
            period_sel = uerl_pkg::PERIOD_5;
        end else begin
            band_sel   = uerl_pkg::BAND_6;
            period_sel = uerl_pkg::PERIOD_6;
        end
    end

    // Blink step, when enabled: nearest band holds the LED on, others toggle on a band change and every period
    always_comb begin
        band_next  = band_reg;
        count_next = count_reg;
        led_next   = led_reg;
        if (meas_strobe && blink_on) begin
            if (band_sel == uerl_pkg::BAND_1) begin
                led_next   = 1'b1;
                band_next  = uerl_pkg::BAND_1;
                count_next = uerl_pkg::BLINK_COUNT_RESET;
            end else if (band_reg != band_sel) begin
                led_next   = ~led_reg;
                band_next  = band_sel;
                count_next = uerl_pkg::BLINK_COUNT_RESET;
            end else if (count_reg == period_sel) begin
                led_next   = ~led_reg;
                count_next = uerl_pkg::BLINK_COUNT_RESET;
            end else if (count_reg < period_sel) begin
                count_next = count_reg + uerl_pkg::COUNT_BITS'(1);
            end
        end
    end

    assign led_next_out = led_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_reg  <= uerl_pkg::BAND_NONE;
            count_reg <= uerl_pkg::BLINK_COUNT_RESET;
            led_reg   <= 1'b0;
        end else begin
            band_reg  <= band_next;
            count_reg <= count_next;
            led_reg   <= led_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uerl_trigger.sv =====
// Trigger pulse timer: loaded by a trigger item, counted down by ticks.
`default_nettype none

module uerl_trigger (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire uerl_pkg::item_ctl_t              ctl,
    input  wire logic [uerl_pkg::TRIG_BITS-1:0]   trigger_width,
    output logic                                  trigger_level
);

    logic [uerl_pkg::TRIG_BITS-1:0] left_reg, left_next;

    // Level shown for this item, then count down or reload
    always_comb begin
        left_next     = left_reg;
        trigger_level = (left_reg != '0);
        if (ctl.trig) begin
            left_next     = trigger_width;
            trigger_level = (trigger_width != '0);
        end else if (ctl.tick && (left_reg != '0)) begin
            left_next = left_reg - uerl_pkg::TRIG_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uerl_checker.sv =====
// Port-level assertions for the echo ranger core, bound to the top level.
`default_nettype none

module uerl_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [uerl_pkg::READ_BITS-1:0] m_read_data,
    input wire logic                          m_data_fresh,
    input wire logic                          m_trigger_level,
    input wire logic                          m_led_level
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result keeps its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_data_fresh) && $stable(m_trigger_level)
            && $stable(m_led_level))
        else $error("stalled result changed");

    // An accepted item is followed by a valid result on m_valid
    a_item_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##1 m_valid)
        else $error("accepted item produced no result");

    // Only a fresh read carries data
    a_stale_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data_fresh |-> m_read_data == '0)
        else $error("read data without fresh flag");

    // A latched echo is at least one tick wide
    a_fresh_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data_fresh |-> m_read_data != '0)
        else $error("fresh read returned zero width");

endmodule

bind ultrasonic_echo_ranger_led_core uerl_checker u_uerl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_read_data     (m_read_data),
    .m_data_fresh    (m_data_fresh),
    .m_trigger_level (m_trigger_level),
    .m_led_level     (m_led_level)
);

`default_nettype wire
